[hdl/iiel_pkg.sv]
// shared types and codes for the indexed insert/erase list
`timescale 1ns / 1ps
`default_nettype none

package iiel_pkg;

	localparam int POS_W   = 7;
	localparam int COUNT_W = 7;
	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		REQ_READ   = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_INSERT = 2'd2,
		REQ_ERASE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_OOB  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// what every cell of the row does on each clock edge
	typedef enum logic [1:0] {
		CL_HOLD   = 2'd0,
		CL_WRITE  = 2'd1,
		CL_INSERT = 2'd2,
		CL_ERASE  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hdl/iiel_cell.sv]
// one storage cell of the list row, shifting with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module iiel_cell
	import iiel_pkg::*;
#(
	parameter int WORD_WIDTH = 32,
	parameter int IDX        = 0
) (
	input  wire logic                  clk,
	input  wire cell_ctl_t             ctl,
	input  wire logic [WORD_WIDTH-1:0] wdata,
	input  wire logic [WORD_WIDTH-1:0] left_data,
	input  wire logic [WORD_WIDTH-1:0] right_data,
	output logic      [WORD_WIDTH-1:0] data,
	output logic      [WORD_WIDTH-1:0] hit_data
);

	logic [WORD_WIDTH-1:0] data_q;
	logic                  at_pos;
	logic                  above_pos;

	assign at_pos    = (int'(ctl.pos) == IDX);
	assign above_pos = (IDX > int'(ctl.pos));

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CL_HOLD: begin
				data_q <= data_q;
			end
			CL_WRITE: begin
				if (at_pos) begin
					data_q <= wdata;
				end
			end
			CL_INSERT: begin
				if (at_pos) begin
					data_q <= wdata;
				end else if (above_pos) begin
					data_q <= left_data;
				end
			end
			CL_ERASE: begin
				if (at_pos || above_pos) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data     = data_q;
	assign hit_data = at_pos ? data_q : '0;

endmodule

`default_nettype wire

[hdl/indexed_insert_erase_list.sv]
// top level of the indexed insert/erase list built as a row of shifting cells
//
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------------------
//  request   | start / busy     | req_type, position, value_in
//  result    | done (strobe)    | status, read_value, element_count, is_empty
//
// one request per cycle: every cell shifts, writes or holds in the accept cycle,
// so the row of DEPTH cells sets the rate at one transaction per clock
// the result shows on the strobe in the cycle after acceptance, for one cycle only
// busy is high for one cycle after reset release, low from then on
// the receiver cannot stall; there is no back-pressure on the result side
// reset clears the count and the control flags; cell contents are not reset
`timescale 1ns / 1ps
`default_nettype none

module indexed_insert_erase_list
	import iiel_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          req_type,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic signed [VALUE_W-1:0] value_in,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [VALUE_W-1:0] read_value,
	output logic [COUNT_W-1:0]       element_count,
	output logic                     is_empty
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// control registers
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	// result payload registers
	status_t              status_q;
	logic [VALUE_W-1:0]   rd_q;

	// request decode
	logic             accept;
	req_t             req;
	status_t          st_now;
	cell_ctl_t        ctl;
	logic [CNT_W-1:0] cnt_next;
	logic [WORD_WIDTH-1:0] wword;

	// cell row wiring
	logic [WORD_WIDTH-1:0] cell_data [DEPTH];
	logic [WORD_WIDTH-1:0] cell_hit  [DEPTH];
	logic [WORD_WIDTH-1:0] hit_or;

	assign accept = start && !busy_q;
	assign req    = req_t'(req_type);

	// stored word: sign-extend the 32-bit input, keep the low WORD_WIDTH bits
	assign wword = WORD_WIDTH'(value_in);

	// status check: insert may address one past the end, others must hit an entry
	always_comb begin
		if (req == REQ_INSERT) begin
			if (int'(position) > int'(cnt_q)) begin
				st_now = ST_OOB;
			end else if (int'(cnt_q) >= DEPTH) begin
				st_now = ST_FULL;
			end else begin
				st_now = ST_DONE;
			end
		end else if (int'(position) >= int'(cnt_q)) begin
			st_now = ST_OOB;
		end else begin
			st_now = ST_DONE;
		end
	end

	// broadcast command for the row, only for accepted requests that succeed
	always_comb begin
		ctl.pos = position;
		ctl.op  = CL_HOLD;
		if (accept && st_now == ST_DONE) begin
			unique case (req)
				REQ_READ:   ctl.op = CL_HOLD;
				REQ_WRITE:  ctl.op = CL_WRITE;
				REQ_INSERT: ctl.op = CL_INSERT;
				REQ_ERASE:  ctl.op = CL_ERASE;
				default:    ctl.op = CL_HOLD;
			endcase
		end
	end

	always_comb begin
		cnt_next = cnt_q;
		unique case (ctl.op)
			CL_INSERT: cnt_next = cnt_q + CNT_W'(1);
			CL_ERASE:  cnt_next = cnt_q - CNT_W'(1);
			default:   cnt_next = cnt_q;
		endcase
	end

	// row of cells: each takes its lower neighbor on insert, upper on erase
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = wword;
		end else begin : g_mid_left
			assign left_w = cell_data[i-1];
		end

		// the top cell shifts in its own word; it is beyond the count after erase
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_right
			assign right_w = cell_data[i+1];
		end

		iiel_cell #(
			.WORD_WIDTH (WORD_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.wdata      (wword),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.hit_data   (cell_hit[i])
		);
	end

	// read-out: only the addressed cell drives a nonzero word
	always_comb begin
		hit_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_or = hit_or | cell_hit[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			cnt_q  <= cnt_next;
		end
	end

	// result payload, captured with the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st_now;
			if (req == REQ_READ && st_now == ST_DONE) begin
				rd_q <= VALUE_W'(hit_or);
			end else begin
				rd_q <= '0;
			end
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign status        = status_q;
	assign read_value    = signed'(rd_q);
	assign element_count = COUNT_W'(cnt_q);
	assign is_empty      = (cnt_q == '0);

	// every accepted transaction gives its strobe in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("no result strobe after accepted request");

	// no strobe without an accepted transaction just before
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result strobe without a request");

	// a failed request leaves the count where it was
	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_DONE |-> element_count == $past(element_count))
		else $error("count changed by a failed request");

	// read data is zero on a failed request
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_DONE |-> read_value == '0)
		else $error("nonzero read data on a failed request");

endmodule

`default_nettype wire

[verif/indexed_insert_erase_list_checker.sv]
// result checker for the indexed insert/erase list: predicts each transaction and compares
`timescale 1ns / 1ps

module indexed_insert_erase_list_checker
	import iiel_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [1:0]               req_type,
	input  logic [POS_W-1:0]         position,
	input  logic signed [VALUE_W-1:0] value_in,
	input  logic                     done,
	input  logic [1:0]               status,
	input  logic signed [VALUE_W-1:0] read_value,
	input  logic [COUNT_W-1:0]       element_count,
	input  logic                     is_empty,
	output int                       mismatch_count,
	output int                       outstanding
);

	typedef struct {
		status_t                  st;
		logic signed [VALUE_W-1:0] word;
		logic [COUNT_W-1:0]       cnt;
		logic                     empty;
	} list_result_t;

	logic signed [VALUE_W-1:0] list_words [DEPTH];
	int                        list_len;
	list_result_t              awaited_results [$];

	function automatic list_result_t apply_request(req_t req, int pos,
			logic signed [VALUE_W-1:0] word);
		list_result_t r;
		r.st   = ST_DONE;
		r.word = '0;
		if (req == REQ_INSERT) begin
			if (pos > list_len) begin
				r.st = ST_OOB;
			end else if (list_len >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				for (int j = list_len; j > pos; j--)
					list_words[j] = list_words[j-1];
				list_words[pos] = word;
				list_len++;
			end
		end else if (pos >= list_len) begin
			r.st = ST_OOB;
		end else begin
			case (req)
				REQ_READ:  r.word = list_words[pos];
				REQ_WRITE: list_words[pos] = word;
				default: begin
					for (int j = pos; j + 1 < list_len; j++)
						list_words[j] = list_words[j+1];
					list_len--;
				end
			endcase
		end
		r.cnt   = COUNT_W'(list_len);
		r.empty = (list_len == 0);
		return r;
	endfunction

	task automatic flag_mismatch(string what, list_result_t exp_r);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%t mismatch (%s): exp st=%0d rd=%0d cnt=%0d empty=%0d, got st=%0d rd=%0d cnt=%0d empty=%0d",
				$realtime, what, exp_r.st, exp_r.word, exp_r.cnt, exp_r.empty,
				status, read_value, element_count, is_empty);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t exp_r;
		if (!arst_n) begin
			list_len       = 0;
			mismatch_count = 0;
			awaited_results.delete();
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					exp_r = '{ST_DONE, '0, '0, 1'b0};
					flag_mismatch("unexpected result", exp_r);
				end else begin
					exp_r = awaited_results.pop_front();
					if (status !== exp_r.st || read_value !== exp_r.word ||
							element_count !== exp_r.cnt || is_empty !== exp_r.empty)
						flag_mismatch("field", exp_r);
				end
			end
			if (start && !busy)
				awaited_results.push_back(apply_request(req_t'(req_type), int'(position),
					value_in));
		end
		outstanding = awaited_results.size();
	end

endmodule

[verif/tb.sv]
// testbench top for the indexed insert/erase list: stimulus, reset and verdict
`timescale 1ns / 1ps

module tb;
	import iiel_pkg::*;

	localparam int DEPTH     = 64;
	localparam int N_RANDOM  = 1080;
	localparam int IDLE_PCT  = 26;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [1:0]                req_type = REQ_READ;
	logic [POS_W-1:0]          position = '0;
	logic signed [VALUE_W-1:0] value_in = '0;
	logic                      done;
	logic [1:0]                status;
	logic signed [VALUE_W-1:0] read_value;
	logic [COUNT_W-1:0]        element_count;
	logic                      is_empty;
	int                        mismatch_count;
	int                        outstanding;

	// rough length of the list as the stimulus sees it, only used to aim positions
	int  list_size_guess;
	// when set, requests go back to back with no idle cycles
	bit  steady;

	indexed_insert_erase_list #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (32)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.position      (position),
		.value_in      (value_in),
		.done          (done),
		.status        (status),
		.read_value    (read_value),
		.element_count (element_count),
		.is_empty      (is_empty)
	);

	indexed_insert_erase_list_checker #(
		.DEPTH (DEPTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.position       (position),
		.value_in       (value_in),
		.done           (done),
		.status         (status),
		.read_value     (read_value),
		.element_count  (element_count),
		.is_empty       (is_empty),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one transaction on the request channel, with random idle cycles ahead of it
	// start is never dropped and raised in the same step: an idle cycle lowers it,
	// the drive edge after that raises it again
	task automatic issue_request(req_t req, int pos, logic signed [VALUE_W-1:0] word);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		req_type <= req;
		position <= POS_W'(pos);
		value_in <= word;
		start    <= 1'b1;
		// wait for the edge that accepts it
		do @(posedge clk); while (busy);
		// keep the position aim roughly in step with the list
		if (req == REQ_INSERT && pos <= list_size_guess && list_size_guess < DEPTH)
			list_size_guess++;
		else if (req == REQ_ERASE && pos < list_size_guess)
			list_size_guess--;
	endtask

	// random position: mostly a legal one for the operation, sometimes anything
	// from 0 to DEPTH so out-of-bounds cases keep showing up
	function automatic int pick_position(req_t req);
		int hi;
		hi = (req == REQ_INSERT) ? list_size_guess : list_size_guess - 1;
		if (hi < 0 || $urandom_range(0, 99) < 12)
			return $urandom_range(0, DEPTH);
		// lean on the ends of the list now and then
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return hi;
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	// request mix per phase: growing, mixed, shrinking, mixed again
	// the growing phase drives the list to full and keeps inserting into it
	function automatic req_t pick_request(int idx);
		int roll;
		roll = $urandom_range(0, 99);
		case ((idx / 100) % 4)
			0: begin
				if (roll < 80)      return REQ_INSERT;
				else if (roll < 85) return REQ_ERASE;
				else if (roll < 93) return REQ_READ;
				else                return REQ_WRITE;
			end
			2: begin
				if (roll < 60)      return REQ_ERASE;
				else if (roll < 70) return REQ_INSERT;
				else if (roll < 88) return REQ_READ;
				else                return REQ_WRITE;
			end
			default: begin
				if (roll < 30)      return REQ_INSERT;
				else if (roll < 55) return REQ_ERASE;
				else if (roll < 80) return REQ_READ;
				else                return REQ_WRITE;
			end
		endcase
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return -32'sd1;
			3:       return '0;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		req_t req;
		int   guard;

		list_size_guess = 0;
		steady          = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty list first, every operation out of bounds
		issue_request(REQ_READ,   0,  32'sd0);
		issue_request(REQ_ERASE,  0,  32'sd0);
		issue_request(REQ_WRITE,  0,  32'sd1);
		issue_request(REQ_INSERT, 1,  32'sd2);
		issue_request(REQ_INSERT, 64, 32'sd3);
		// build a short list: front, back and middle inserts with extreme words
		issue_request(REQ_INSERT, 0,  32'sh8000_0000);
		issue_request(REQ_INSERT, 1,  32'sh7fff_ffff);
		issue_request(REQ_INSERT, 0,  -32'sd1);
		issue_request(REQ_INSERT, 1,  32'sd0);
		for (int i = 0; i < 4; i++)
			issue_request(REQ_READ, i, 32'sd0);
		// one past the last entry
		issue_request(REQ_READ,   4,  32'sd0);
		issue_request(REQ_WRITE,  2,  32'sh5555_5555);
		issue_request(REQ_WRITE,  4,  32'shaaaa_aaaa);
		issue_request(REQ_WRITE,  0,  32'shaaaa_aaaa);
		issue_request(REQ_READ,   2,  32'sd0);
		// erase in the middle, then the last entry, then down to empty
		issue_request(REQ_ERASE,  1,  32'sd0);
		issue_request(REQ_ERASE,  2,  32'sd0);
		issue_request(REQ_READ,   0,  32'sd0);
		issue_request(REQ_READ,   1,  32'sd0);
		issue_request(REQ_ERASE,  0,  32'sd0);
		issue_request(REQ_ERASE,  0,  32'sd0);
		issue_request(REQ_READ,   0,  32'sd0);

		// random part; a long stretch in the middle runs back to back
		for (int n = 0; n < N_RANDOM; n++) begin
			steady = (n >= 450 && n < 650);
			req    = pick_request(n);
			issue_request(req, pick_position(req), pick_word());
		end
		start <= 1'b0;

		// drain: sampled on the falling edge, away from the checker's updates
		guard = 0;
		while (outstanding != 0 && guard < 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);

		if (outstanding != 0)
			$display("%0d results never arrived", outstanding);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#200000;
		$display("simulation failed");
		$finish;
	end

endmodule
